// File: src/smf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter package
// Widths, reset values and the control bundle shared by the filter modules.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int SAMPLE_W     = 32;
   localparam int CSR_W        = 12;
   localparam int WINDOW_RESET = 5;

   // Control from the sequencer to the merge unit, one bundle per cycle.
   typedef struct packed {
      logic start;
      logic remove_en;
      logic data_valid;
      logic finish;
   } merge_ctrl_type;

endpackage

// File: src/sliding_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter
// Median of the most recent window_size signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Each request transaction carries one sample; it is stored in a circular
// history RAM and merged into a sorted-sample RAM, and one response
// transaction returns the median of the samples held. While the window
// fills, the median is taken over the samples received so far; for an even
// count the two middle values are averaged, rounding toward minus infinity.
// A transaction occupies the sequencer from its acceptance: it is accepted,
// the n samples held before it arrives are streamed from the sorted RAM
// through its single read port one entry per cycle and the read pipeline is
// drained, the two middle entries are fetched and the output register is
// loaded, which waits while a previous response is stalled. A full window
// adds a step that fetches the departing sample and an even count adds one
// for the average. One transaction is processed at a time; a finished
// response waits in the output register while the next request is taken.
// Writing window_size (0 acts as 1, values above MAX_WINDOW saturate) empties
// the window. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sliding_median_filter #(
   parameter int MAX_WINDOW = 4095
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [smf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [smf_pkg::SAMPLE_W-1:0] rsp_median,
   input  logic                                csr_write_enable,
   input  logic [smf_pkg::CSR_W-1:0]           csr_write_data
);

   import smf_pkg::*;

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [CW-1:0] RESET_WINDOW =
      CW'((WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HIST,
      S_SCAN,
      S_MED_HI,
      S_MED_LO,
      S_EVEN,
      S_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              window_ff, window_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] old_ff, old_in;
   logic                       remove_en_ff, remove_en_in;
   logic [CW-1:0]              n_old_ff, n_old_in;
   logic [CW-1:0]              rd_idx_ff, rd_idx_in;
   logic                       arr_ff, arr_in;
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in;
   logic signed [SAMPLE_W-1:0] med_ff, med_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_median_ff, rsp_median_in;

   logic                       req_accept;
   logic                       full;
   logic [CW-1:0]              mid;
   logic signed [SAMPLE_W:0]   pair_sum;

   // History RAM ports.
   logic                       hist_we;
   logic [AW-1:0]              hist_waddr;
   logic signed [SAMPLE_W-1:0] hist_wdata;
   logic signed [SAMPLE_W-1:0] hist_rdata;

   // Sorted RAM ports.
   logic [AW-1:0]              sort_raddr;
   logic signed [SAMPLE_W-1:0] sort_rdata;
   logic                       sort_we;
   logic [CW-1:0]              sort_windex;
   logic signed [SAMPLE_W-1:0] sort_wdata;

   merge_ctrl_type             merge_ctrl;

   // Register write value: zero acts as one, large values saturate.
   function automatic logic [CW-1:0] clamp_window(input logic [CSR_W-1:0] value);
      logic [CSR_W-1:0] w;
      w = value;
      if (w == '0) begin
         w = CSR_W'(1);
      end
      if (w > CSR_W'(MAX_WINDOW)) begin
         w = CSR_W'(MAX_WINDOW);
      end
      return CW'(w);
   endfunction

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign full       = (fill_ff >= window_ff);
   assign mid        = fill_ff >> 1;
   assign pair_sum   = {sort_rdata[SAMPLE_W-1], sort_rdata} + {hi_ff[SAMPLE_W-1], hi_ff};

   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      sample_in     = sample_ff;
      old_in        = old_ff;
      remove_en_in  = remove_en_ff;
      n_old_in      = n_old_ff;
      rd_idx_in     = rd_idx_ff;
      arr_in        = 1'b0;
      hi_in         = hi_ff;
      med_in        = med_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;

      hist_we    = 1'b0;
      hist_waddr = ptr_ff;
      hist_wdata = sample_ff;
      sort_raddr = rd_idx_ff[AW-1:0];
      merge_ctrl = '{start: 1'b0, remove_en: remove_en_ff, data_valid: 1'b0,
                     finish: 1'b0};

      // The output register drains independently of the sequencer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               sample_in        = req_sample;
               n_old_in         = fill_ff;
               remove_en_in     = full;
               rd_idx_in        = '0;
               merge_ctrl.start = 1'b1;
               if (full) begin
                  // The departing sample is read at ptr_ff this cycle.
                  state_in = S_HIST;
               end else begin
                  hist_we    = 1'b1;
                  hist_waddr = fill_ff[AW-1:0];
                  hist_wdata = req_sample;
                  fill_in    = fill_ff + 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_HIST: begin
            old_in  = hist_rdata;
            hist_we = 1'b1;
            if ((CW'(ptr_ff) + 1'b1) == window_ff) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
            state_in = S_SCAN;
         end
         S_SCAN: begin
            merge_ctrl.data_valid = arr_ff;
            if (rd_idx_ff != n_old_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               arr_in    = 1'b1;
            end else if (!arr_ff) begin
               merge_ctrl.finish = 1'b1;
               state_in          = S_MED_HI;
            end
         end
         S_MED_HI: begin
            sort_raddr = mid[AW-1:0];
            state_in   = S_MED_LO;
         end
         S_MED_LO: begin
            hi_in      = sort_rdata;
            sort_raddr = AW'(mid - 1'b1);
            if (fill_ff[0]) begin
               med_in   = sort_rdata;
               state_in = S_OUT;
            end else begin
               state_in = S_EVEN;
            end
         end
         S_EVEN: begin
            // Floor average of the two middle samples.
            med_in   = pair_sum[SAMPLE_W:1];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = med_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write empties the window; write it only while idle.
      if (csr_write_enable) begin
         window_in = clamp_window(csr_write_data);
         fill_in   = '0;
         ptr_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= RESET_WINDOW;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         arr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         arr_ff       <= arr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff     <= sample_in;
      old_ff        <= old_in;
      remove_en_ff  <= remove_en_in;
      n_old_ff      <= n_old_in;
      rd_idx_ff     <= rd_idx_in;
      hi_ff         <= hi_in;
      med_ff        <= med_in;
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

   smf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW),
      .AW    (AW)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (ptr_ff),
      .rd_data (hist_rdata)
   );

   smf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW),
      .AW    (AW)
   ) u_sorted_ram (
      .clock   (clock),
      .wr_en   (sort_we),
      .wr_addr (sort_windex[AW-1:0]),
      .wr_data (sort_wdata),
      .rd_addr (sort_raddr),
      .rd_data (sort_rdata)
   );

   smf_merge #(
      .CW (CW)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (merge_ctrl),
      .old_value (old_ff),
      .new_value (sample_ff),
      .rd_data   (sort_rdata),
      .wr_en     (sort_we),
      .wr_index  (sort_windex),
      .wr_data   (sort_wdata)
   );

   // The window never holds more samples than its size.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= window_ff)
      else $error("fill count exceeds window size");

   // The circular pointer stays inside the window.
   assert property (@(posedge clock) disable iff (reset) CW'(ptr_ff) < window_ff)
      else $error("oldest pointer outside window");

   // While the window fills, every accepted transaction adds one sample.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !full && !csr_write_enable) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count did not advance");

   // Write-back during the scan never overtakes entries still to be read.
   assert property (@(posedge clock) disable iff (reset)
      (sort_we && merge_ctrl.data_valid) |-> sort_windex < rd_idx_ff)
      else $error("sorted write overtook the read stream");

endmodule

// File: src/smf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module smf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4095,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/smf_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter merge unit
// Streams the sorted store once, drops one copy of the departing sample when
// remove_en is set, inserts the new one and produces the write-back stream.
// ----------------------------------------------------------------------------
module smf_merge #(
   parameter int CW = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  smf_pkg::merge_ctrl_type              ctrl,
   input  logic signed [smf_pkg::SAMPLE_W-1:0]  old_value,
   input  logic signed [smf_pkg::SAMPLE_W-1:0]  new_value,
   input  logic signed [smf_pkg::SAMPLE_W-1:0]  rd_data,
   output logic                                 wr_en,
   output logic [CW-1:0]                        wr_index,
   output logic signed [smf_pkg::SAMPLE_W-1:0]  wr_data
);

   import smf_pkg::*;

   logic                       removed_ff, removed_in;
   logic                       inserted_ff, inserted_in;
   logic signed [SAMPLE_W-1:0] carry_ff, carry_in;
   logic [CW-1:0]              count_ff, count_in;

   // Once the new sample is written, the stream runs one entry behind the
   // reads, so the write index never reaches an entry not yet read.
   always_comb begin
      removed_in  = removed_ff;
      inserted_in = inserted_ff;
      carry_in    = carry_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_data     = carry_ff;
      if (ctrl.start) begin
         removed_in  = 1'b0;
         inserted_in = 1'b0;
         count_in    = '0;
      end else if (ctrl.data_valid) begin
         if (ctrl.remove_en && !removed_ff && (rd_data == old_value)) begin
            removed_in = 1'b1;
         end else if (!inserted_ff && (rd_data > new_value)) begin
            wr_en       = 1'b1;
            wr_data     = new_value;
            inserted_in = 1'b1;
            carry_in    = rd_data;
            count_in    = count_ff + 1'b1;
         end else if (inserted_ff) begin
            wr_en    = 1'b1;
            wr_data  = carry_ff;
            carry_in = rd_data;
            count_in = count_ff + 1'b1;
         end else begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            count_in = count_ff + 1'b1;
         end
      end else if (ctrl.finish) begin
         wr_en    = 1'b1;
         wr_data  = inserted_ff ? carry_ff : new_value;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         removed_ff  <= 1'b0;
         inserted_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         removed_ff  <= removed_in;
         inserted_ff <= inserted_in;
         count_ff    <= count_in;
      end
      carry_ff <= carry_in;
   end

   assign wr_index = count_ff;

endmodule

// File: tb/tb_sliding_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median filter testbench
// Drives sample transactions and window_size writes into the filter and
// checks every median it returns against an independent sliding-window model.
// ----------------------------------------------------------------------------
// A short directed run covers the reset window, the sample extremes, even
// counts that round toward minus infinity, repeated values and the window
// sizes 0, 2 and 4095. Random segments follow, each one opening with a new
// window_size write made while the filter is idle. Both channels pause at
// random, and one long response hold-off lets the filter back up and stall
// its request channel.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter;

   import smf_pkg::*;

   localparam int MAX_WINDOW      = 4095;
   localparam int RUN_CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS    = 114;
   localparam int REPORT_LIMIT    = 10;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type MOST_POSITIVE = 32'sh7FFF_FFFF;
   localparam sample_type MOST_NEGATIVE = 32'sh8000_0000;

   // -------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of the sample history and of the
   // sorted window, predicts one median per accepted sample and compares the
   // returned medians against those predictions in order.
   // -------------------------------------------------------------------------
   class median_scoreboard;
      int unsigned window;
      sample_type  history [MAX_WINDOW];
      sample_type  ordered [MAX_WINDOW];
      int unsigned held;
      int unsigned oldest;
      sample_type  median_q [$];
      int unsigned errors;

      function new();
         window = WINDOW_RESET;
         held   = 0;
         oldest = 0;
         errors = 0;
      endfunction

      // A write of zero acts as a window of one, and any write empties the
      // window.
      function void set_window(logic [CSR_W-1:0] value);
         window = 32'(value);
         if (window < 1) window = 1;
         if (window > MAX_WINDOW) window = MAX_WINDOW;
         held   = 0;
         oldest = 0;
      endfunction

      function void note_sample(sample_type s);
         int unsigned           slot;
         int unsigned           idx;
         int unsigned           mid;
         sample_type            departing;
         logic signed [SAMPLE_W:0] total;
         sample_type            median;
         if (held >= window) begin
            // Full window: the oldest sample leaves the sorted store. Any
            // entry of equal value will do.
            slot      = oldest % window;
            departing = history[slot];
            idx       = 0;
            while (idx < held && ordered[idx] != departing) idx++;
            if (idx < held) begin
               for (; idx + 1 < held; idx++) ordered[idx] = ordered[idx + 1];
               held--;
            end
            history[slot] = s;
            oldest        = (slot + 1) % window;
         end else begin
            history[(oldest + held) % window] = s;
         end
         idx = held;
         while (idx > 0 && ordered[idx - 1] > s) begin
            ordered[idx] = ordered[idx - 1];
            idx--;
         end
         ordered[idx] = s;
         held++;
         mid = held / 2;
         if (held % 2 == 1) begin
            median = ordered[mid];
         end else begin
            // The 33-bit sum shifted right by one rounds toward minus infinity.
            total  = {ordered[mid - 1][SAMPLE_W-1], ordered[mid - 1]}
                   + {ordered[mid][SAMPLE_W-1], ordered[mid]};
            median = total[SAMPLE_W:1];
         end
         median_q.push_back(median);
      endfunction

      function void check_median(sample_type got);
         sample_type want;
         if (median_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR: median %0d (0x%08h) returned with none expected",
                        got, got);
         end else begin
            want = median_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("ERROR: median expected %0d (0x%08h), got %0d (0x%08h)",
                           want, want, got, got);
            end
         end
      endfunction

      function int pending();
         return median_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block under test. All inputs hold known values
   // from time zero.
   // -------------------------------------------------------------------------
   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   sample_type              req_sample       = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   sample_type              rsp_median;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_W-1:0]        csr_write_data   = '0;

   median_scoreboard sb = new();

   // Pause rates in percent, and the length of a pending response hold-off.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned hold_left     = 0;
   int unsigned cycle_count   = 0;

   sliding_median_filter #(
      .MAX_WINDOW(MAX_WINDOW)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median       (rsp_median),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog. The slowest legal run is far below this limit, since no
   // window ever holds more than a few dozen samples.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The response side. The stall changes on the falling edge; a pending
   // hold-off keeps it high for a long run of cycles so that the filter
   // fills up behind it, otherwise it is raised at the current pause rate.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // A response transaction completes at a rising edge with valid high and
   // stall low. The values are read before the edge updates take effect.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_median(rsp_median);
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks. Each is entered just after a falling edge and returns
   // just after one.
   // -------------------------------------------------------------------------

   // Offers one sample, with random pauses before it, and holds it steady
   // until the filter accepts it. The payload is scrambled while invalid.
   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid  = 1'b0;
         req_sample = $urandom;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = s;
      do @(posedge clock); while (req_stall);
      sb.note_sample(s);
      @(negedge clock);
   endtask

   // The window register is written only once every predicted median has
   // come back. Each sample yields exactly one median, so the filter is idle
   // at that point.
   task automatic write_window(input logic [CSR_W-1:0] value);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_window(value);
   endtask

   // Mostly small window sizes so that the window wraps often, with the
   // boundary values and an occasional large one.
   function automatic logic [CSR_W-1:0] pick_window();
      case ($urandom_range(9))
         0:       return '0;
         1:       return CSR_W'(1);
         2:       return CSR_W'(MAX_WINDOW);
         8:       return CSR_W'($urandom_range(13, 64));
         9:       return CSR_W'($urandom_range(65, MAX_WINDOW));
         default: return CSR_W'($urandom_range(2, 12));
      endcase
   endfunction

   // Half the samples are fully random; the rest are tiny values that repeat
   // often, the extremes, or small positive fixed-point values.
   function automatic sample_type pick_sample();
      case ($urandom_range(9)) inside
         [5:7]:   return sample_type'(int'($urandom_range(6)) - 3);
         8:       return $urandom_range(1) ? MOST_POSITIVE : MOST_NEGATIVE;
         9:       return sample_type'($urandom & 32'h0003_FFFF);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int          items_left;
      int          batch;
      bit          pressure_done;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with the sender pausing now and then and the receiver
      // pausing most of the time.
      send_idle_pct = 26;
      rsp_idle_pct  = 86;

      // Reset window of five: extremes, even counts that must round down,
      // and a full window that drops extremes and repeated values.
      send_sample(0);
      send_sample(-1);
      send_sample(MOST_POSITIVE);
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(32'sh0005_0000);
      send_sample(32'sh0005_0000);
      send_sample(32'sh0005_0000);
      send_sample(-1);

      // A write of zero acts as a window of one: every median is its sample.
      write_window(CSR_W'(0));
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(3);

      // A window of two is always an even count once full, including the
      // largest and smallest possible sums.
      write_window(CSR_W'(2));
      send_sample(MOST_POSITIVE);
      send_sample(MOST_POSITIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(MOST_NEGATIVE);
      send_sample(-1);
      send_sample(0);
      send_sample(1);

      // The largest window, filled only a little.
      write_window(CSR_W'(MAX_WINDOW));
      send_sample(MOST_NEGATIVE);
      send_sample(MOST_POSITIVE);
      send_sample(-3);
      send_sample(-3);
      send_sample(17);

      // Random part in three phases: first the receiver pauses most, then the
      // sender, then neither. Each batch starts on a fresh window size. In the
      // last phase one long response hold-off is raised while the sender
      // keeps offering samples.
      pressure_done = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 26; rsp_idle_pct = 86; end
            1: begin send_idle_pct = 86; rsp_idle_pct = 26; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         items_left = RANDOM_ITEMS / 3;
         while (items_left > 0) begin
            write_window(pick_window());
            batch = $urandom_range(4, 20);
            if (batch > items_left) batch = items_left;
            if (phase == 2 && !pressure_done) begin
               hold_left     = 400;
               pressure_done = 1'b1;
            end
            repeat (batch) send_sample(pick_sample());
            items_left -= batch;
         end
      end
      req_valid = 1'b0;

      // Drain, then give any stray response time to show up.
      while (sb.pending() != 0) @(negedge clock);
      repeat (32) @(negedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sliding_median_filter.f
src/smf_pkg.sv
src/smf_ram.sv
src/smf_merge.sv
src/sliding_median_filter.sv
tb/tb_sliding_median_filter.sv
